### rtl/sss_pkg.sv
`timescale 1ns / 1ps

package sss_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_ID      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_CODE    = 2'd3;

  localparam logic [15:0] WAIT_TICKS_RST   = 16'd3500;
  localparam logic [15:0] ROTATE_TICKS_RST = 16'd5400;
  localparam logic [10:0] TRIG_ID_RST      = 11'h552;
  localparam logic [7:0]  TRIG_CODE_RST    = 8'd84;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_FRAME = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_WAIT1 = 4'd1,
    ST_SEG1  = 4'd2,
    ST_SEG2  = 4'd3,
    ST_SEG3  = 4'd4,
    ST_SEG4  = 4'd5,
    ST_SEG5  = 4'd6,
    ST_SEG6  = 4'd7,
    ST_PAUSE = 4'd8,
    ST_WAIT2 = 4'd9,
    ST_FINAL = 4'd10,
    ST_DONE  = 4'd11
  } stage_t;

  typedef struct packed {
    logic        func;
    logic [10:0] frame_id;
    logic [7:0]  command_byte;
  } in_item_t;

  typedef struct packed {
    logic       coil_a;
    logic       coil_b;
    logic [1:0] phase;
    logic [3:0] stage;
    logic       finished;
  } out_item_t;

  typedef struct packed {
    logic [15:0] wait_ticks;
    logic [15:0] rotate_ticks;
    logic [10:0] trigger_frame_id;
    logic [7:0]  trigger_code;
  } sss_cfg_t;

endpackage

### rtl/stepper_shot_sequencer.sv
`timescale 1ns / 1ps

// Full-step sequencer for a two-coil stepper, started by a trigger frame and paced by
// timer ticks. Every request, tick or frame, produces exactly one result carrying the
// coil levels, phase and stage after that request. A request is taken into an input
// register; once the output register is free or its result is taken, the sequencer
// state is updated and the result lands in the output register at the same edge, and
// one request can be accepted every cycle while results are taken. Configuration
// writes take effect at once and should be made while no request is in flight.
module stepper_shot_sequencer
  import sss_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sss_cfg_t  cfg;
  in_item_t  in_q;
  logic      in_vld_q;
  logic      adv;
  logic      step;
  out_item_t result;

  assign adv      = !out_valid || out_ready;
  assign in_ready = !in_vld_q || adv;
  assign step     = in_vld_q && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_vld_q;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

  sss_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sss_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

endmodule

### rtl/sss_cfg_regs.sv
`timescale 1ns / 1ps

module sss_cfg_regs
  import sss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output sss_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_ticks       <= WAIT_TICKS_RST;
      cfg.rotate_ticks     <= ROTATE_TICKS_RST;
      cfg.trigger_frame_id <= TRIG_ID_RST;
      cfg.trigger_code     <= TRIG_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WAIT_TICKS:   cfg.wait_ticks       <= cfg_data;
        CFG_ROTATE_TICKS: cfg.rotate_ticks     <= cfg_data;
        CFG_TRIG_ID:      cfg.trigger_frame_id <= cfg_data[10:0];
        CFG_TRIG_CODE:    cfg.trigger_code     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/sss_core.sv
`timescale 1ns / 1ps

module sss_core
  import sss_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  input  sss_cfg_t  cfg,
  output out_item_t result
);

  stage_t                 stage, stage_next;
  logic [COUNT_WIDTH-1:0] countdown, countdown_next;
  logic [1:0]             phase, phase_next;

  logic                   is_tick;
  logic                   hit;
  logic                   is_seg;
  logic                   cnt_live;
  logic                   cnt_end;
  logic [COUNT_WIDTH-1:0] cnt_dec;

  assign is_tick  = (item.func == FUNC_TICK);
  assign hit      = (item.func == FUNC_FRAME) && (item.frame_id == cfg.trigger_frame_id) &&
                    (item.command_byte == cfg.trigger_code);
  assign is_seg   = ((stage >= ST_SEG1) && (stage <= ST_SEG6)) || (stage == ST_FINAL);
  assign cnt_live = (countdown != '0);
  assign cnt_dec  = countdown - COUNT_WIDTH'(1);
  assign cnt_end  = cnt_live && (cnt_dec == '0);

  always_comb begin
    stage_next = stage;
    if (step) begin
      if (is_tick) begin
        if (cnt_end) begin
          case (stage)
            ST_WAIT1: stage_next = ST_SEG1;
            ST_SEG1:  stage_next = ST_SEG2;
            ST_SEG2:  stage_next = ST_SEG3;
            ST_SEG3:  stage_next = ST_SEG4;
            ST_SEG4:  stage_next = ST_SEG5;
            ST_SEG5:  stage_next = ST_SEG6;
            ST_SEG6:  stage_next = ST_PAUSE;
            ST_WAIT2: stage_next = ST_FINAL;
            ST_FINAL: stage_next = ST_DONE;
            default:  stage_next = stage;
          endcase
        end
      end else if (hit) begin
        case (stage)
          ST_IDLE:  stage_next = ST_WAIT1;
          ST_PAUSE: stage_next = ST_WAIT2;
          default:  stage_next = stage;
        endcase
      end
    end
  end

  always_comb begin
    countdown_next = countdown;
    phase_next     = phase;
    if (step) begin
      if (is_tick) begin
        if (is_seg) begin
          phase_next = stage[0] ? (phase - 2'd1) : (phase + 2'd1);
        end
        if ((is_seg || stage == ST_WAIT1 || stage == ST_WAIT2) && cnt_live) begin
          countdown_next = cnt_dec;
          if (cnt_end && stage != ST_SEG6 && stage != ST_FINAL) begin
            countdown_next = COUNT_WIDTH'(cfg.rotate_ticks);
          end
        end
      end else if (hit && (stage == ST_IDLE || stage == ST_PAUSE)) begin
        countdown_next = COUNT_WIDTH'(cfg.wait_ticks);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= ST_IDLE;
      countdown <= '0;
      phase     <= 2'd0;
    end else begin
      stage     <= stage_next;
      countdown <= countdown_next;
      phase     <= phase_next;
    end
  end

  assign result.coil_a   = phase_next[1];
  assign result.coil_b   = phase_next[1] ^ phase_next[0];
  assign result.phase    = phase_next;
  assign result.stage    = stage_next;
  assign result.finished = (stage_next == ST_DONE);

endmodule

### rtl/sss_checker.sv
`timescale 1ns / 1ps

module sss_checker
  import sss_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result must be held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The coil levels follow the reported phase.
  a_coils: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.coil_a == out_data.phase[1]) &&
                  (out_data.coil_b == (out_data.phase[1] ^ out_data.phase[0])))
    else $error("coil levels do not match phase");

  // The finished flag is set exactly in the done stage.
  a_finished: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.finished == (out_data.stage == ST_DONE)))
    else $error("finished flag does not match stage");

  // Once the sequence has completed it stays completed until reset.
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.finished |=> !out_valid || out_data.finished)
    else $error("sequence left the done stage");

endmodule

bind stepper_shot_sequencer sss_checker u_sss_checker (.*);
